/* src/bpu_pkg.sv */
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared types and constants of the bitmap pixel unpacker.
// ----------------------------------------------------------------------------
package bpu_pkg;

  localparam int DEF_MAX_WIDTH     = 256;
  localparam int DEF_PALETTE_DEPTH = 256;

  typedef enum logic [2:0] {
    FMT_1BIT   = 3'd0,
    FMT_4BIT   = 3'd1,
    FMT_8BIT   = 3'd2,
    FMT_BGR24  = 3'd3,
    FMT_BGRA32 = 3'd4
  } fmt_t;

  typedef enum logic [1:0] {
    CFG_FORMAT = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_PIXEL   = 1'b1;

  typedef struct packed {
    logic [2:0] fmt;
    logic [8:0] width;
    logic [8:0] height;
  } cfg_t;

  // One pixel handed from the sequencer to the palette read stage.
  typedef struct packed {
    logic        valid;
    logic        direct;
    logic [31:0] color;
    logic [7:0]  pal_idx;
    logic [7:0]  col;
    logic [7:0]  row;
    logic        last;
    logic        done;
  } issue_t;

  typedef struct packed {
    logic       in_ready;
    logic [3:0] left;
  } seq_status_t;

endpackage

/* src/bpu_palette_ram.sv */
// ----------------------------------------------------------------------------
// bpu_palette_ram
// Palette store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpu_palette_ram
  import bpu_pkg::*;
#(
  parameter int DEPTH = DEF_PALETTE_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/bpu_byte_sequencer.sv */
// ----------------------------------------------------------------------------
// bpu_byte_sequencer
// Tracks row position, column and file row, gathers true color bytes and
// issues the pixels of one data byte, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module bpu_byte_sequencer
  import bpu_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        restart,
  input  logic        adv,
  input  logic        acc_pixel,
  input  logic [7:0]  data_byte,
  output issue_t      issue,
  output seq_status_t status
);

  localparam logic [12:0] MAX_W = 13'(MAX_WIDTH);

  logic [10:0] pos_r, pos_nxt;
  logic [8:0]  col_r, col_nxt;
  logic [8:0]  frow_r, frow_nxt;
  logic [23:0] gath_r, gath_nxt;
  logic [1:0]  lane_r, lane_nxt;

  logic [3:0]  left_r, left_nxt;
  logic [7:0]  sbyte_r, sbyte_nxt;
  fmt_t        sfmt_r, sfmt_nxt;
  logic [8:0]  scol_r, scol_nxt;
  logic [7:0]  srow_r, srow_nxt;
  logic        slrow_r, slrow_nxt;
  logic [31:0] scolor_r, scolor_nxt;

  fmt_t        fmt_e;
  logic [8:0]  w_e, h_e, frow_e, rem, frow_inc, row_full;
  logic [10:0] w11, packed_len, stride;
  logic        in_packed, complete, row_end, fire;
  logic [3:0]  n;
  logic [31:0] color;
  logic [23:0] gath_upd;
  logic [1:0]  lane_upd;

  always_comb begin
    fmt_e = (cfg.fmt > 3'(FMT_BGRA32)) ? FMT_BGRA32 : fmt_t'(cfg.fmt);
    if (cfg.width == 9'd0) begin
      w_e = 9'd1;
    end else if ({4'b0, cfg.width} > MAX_W) begin
      w_e = MAX_W[8:0];
    end else begin
      w_e = cfg.width;
    end
    if (cfg.height == 9'd0) begin
      h_e = 9'd1;
    end else if (cfg.height > 9'd256) begin
      h_e = 9'd256;
    end else begin
      h_e = cfg.height;
    end
    w11 = {2'b0, w_e};
    unique case (fmt_e)
      FMT_1BIT:  packed_len = (w11 + 11'd7) >> 3;
      FMT_4BIT:  packed_len = (w11 + 11'd1) >> 1;
      FMT_8BIT:  packed_len = w11;
      FMT_BGR24: packed_len = w11 + (w11 << 1);
      default:   packed_len = w11 << 2;
    endcase
    stride    = (packed_len + 11'd3) & ~11'd3;
    frow_e    = (frow_r >= h_e) ? 9'd0 : frow_r;
    in_packed = pos_r < packed_len;
    rem       = w_e - col_r;
    complete  = (fmt_e == FMT_BGR24) ? (lane_r == 2'd2) : (lane_r == 2'd3);
    color     = (fmt_e == FMT_BGR24) ? {8'hFF, data_byte, gath_r[15:0]}
                                     : {data_byte, gath_r};
    n = 4'd0;
    if (in_packed) begin
      unique case (fmt_e)
        FMT_1BIT: n = (rem >= 9'd8) ? 4'd8 : rem[3:0];
        FMT_4BIT: n = (rem >= 9'd2) ? 4'd2 : rem[3:0];
        FMT_8BIT: n = (rem != 9'd0) ? 4'd1 : 4'd0;
        default:  n = (complete && rem != 9'd0) ? 4'd1 : 4'd0;
      endcase
    end
    gath_upd = gath_r;
    lane_upd = lane_r;
    if (in_packed && (fmt_e == FMT_BGR24 || fmt_e == FMT_BGRA32)) begin
      if (complete) begin
        gath_upd = 24'd0;
        lane_upd = 2'd0;
      end else begin
        lane_upd = lane_r + 2'd1;
        unique case (lane_r)
          2'd0:    gath_upd = gath_r | {16'd0, data_byte};
          2'd1:    gath_upd = gath_r | {8'd0, data_byte, 8'd0};
          2'd2:    gath_upd = gath_r | {data_byte, 16'd0};
          default: gath_upd = gath_r;
        endcase
      end
    end
    row_end  = ({1'b0, pos_r} + 12'd1) >= {1'b0, stride};
    frow_inc = frow_e + 9'd1;
    row_full = h_e - 9'd1 - frow_e;
  end

  assign fire = (left_r != 4'd0) && adv;
  assign status.in_ready = (left_r == 4'd0) || ((left_r == 4'd1) && adv);
  assign status.left = left_r;

  always_comb begin
    pos_nxt    = pos_r;
    col_nxt    = col_r;
    frow_nxt   = frow_r;
    gath_nxt   = gath_r;
    lane_nxt   = lane_r;
    left_nxt   = left_r;
    sbyte_nxt  = sbyte_r;
    sfmt_nxt   = sfmt_r;
    scol_nxt   = scol_r;
    srow_nxt   = srow_r;
    slrow_nxt  = slrow_r;
    scolor_nxt = scolor_r;
    if (fire) begin
      left_nxt = left_r - 4'd1;
      scol_nxt = scol_r + 9'd1;
      unique case (sfmt_r)
        FMT_1BIT: sbyte_nxt = sbyte_r << 1;
        FMT_4BIT: sbyte_nxt = sbyte_r << 4;
        default:  sbyte_nxt = sbyte_r;
      endcase
    end
    if (acc_pixel) begin
      left_nxt   = n;
      sbyte_nxt  = data_byte;
      sfmt_nxt   = fmt_e;
      scol_nxt   = col_r;
      srow_nxt   = row_full[7:0];
      slrow_nxt  = (frow_e == h_e - 9'd1);
      scolor_nxt = color;
      if (row_end) begin
        pos_nxt  = 11'd0;
        col_nxt  = 9'd0;
        gath_nxt = 24'd0;
        lane_nxt = 2'd0;
        frow_nxt = (frow_inc >= h_e) ? 9'd0 : frow_inc;
      end else begin
        pos_nxt  = pos_r + 11'd1;
        col_nxt  = col_r + {5'd0, n};
        frow_nxt = frow_e;
        gath_nxt = gath_upd;
        lane_nxt = lane_upd;
      end
    end
    if (restart) begin
      pos_nxt  = 11'd0;
      col_nxt  = 9'd0;
      frow_nxt = 9'd0;
      gath_nxt = 24'd0;
      lane_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      col_r  <= '0;
      frow_r <= '0;
      gath_r <= '0;
      lane_r <= '0;
      left_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      col_r  <= col_nxt;
      frow_r <= frow_nxt;
      gath_r <= gath_nxt;
      lane_r <= lane_nxt;
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sbyte_r  <= sbyte_nxt;
    sfmt_r   <= sfmt_nxt;
    scol_r   <= scol_nxt;
    srow_r   <= srow_nxt;
    slrow_r  <= slrow_nxt;
    scolor_r <= scolor_nxt;
  end

  always_comb begin
    issue.valid  = left_r != 4'd0;
    issue.direct = (sfmt_r == FMT_BGR24) || (sfmt_r == FMT_BGRA32);
    issue.color  = scolor_r;
    unique case (sfmt_r)
      FMT_1BIT: issue.pal_idx = {7'd0, sbyte_r[7]};
      FMT_4BIT: issue.pal_idx = {4'd0, sbyte_r[7:4]};
      default:  issue.pal_idx = sbyte_r;
    endcase
    issue.col  = scol_r[7:0];
    issue.row  = srow_r;
    issue.last = left_r == 4'd1;
    issue.done = slrow_r && (scol_r == w_e - 9'd1);
  end

endmodule

/* src/bitmap_pixel_unpacker.sv */
// ----------------------------------------------------------------------------
// bitmap_pixel_unpacker
// A data byte's first pixel passes the sequencer's issue registers, the palette
// read stage and the output register. Throughput: one pixel per cycle through
// the single palette read port unless the output stalls; a new byte is taken as
// the last pixel of the one before issues. Reset is synchronous and active low;
// it resets counters, pipeline valid bits and configuration, not the palette.
// ----------------------------------------------------------------------------
module bitmap_pixel_unpacker
  import bpu_pkg::*;
#(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // palette_index[7:0], palette_color[39:8], data_byte[47:40]
  input  logic [47:0] in_tdata,
  // command
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // red, green, blue, alpha, column, row from the lowest byte up
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  // image_done
  output logic        out_tuser
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  cfg_t        cfg_r, cfg_nxt;
  logic        restart;
  logic        adv, acc, acc_pixel, pal_we;
  issue_t      issue;
  seq_status_t status;
  logic [31:0] rdata, color_nxt;

  logic        m_valid_r, m_direct_r, m_oob_r, m_last_r, m_done_r;
  logic [31:0] m_color_r;
  logic [7:0]  m_col_r, m_row_r;
  logic        out_valid_r, out_last_r, out_done_r;
  logic [47:0] out_data_r;

  always_comb begin
    cfg_nxt = cfg_r;
    restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FORMAT: begin
          cfg_nxt.fmt = cfg_wdata[2:0];
          restart     = 1'b1;
        end
        CFG_WIDTH: begin
          cfg_nxt.width = cfg_wdata;
          restart       = 1'b1;
        end
        CFG_HEIGHT: begin
          cfg_nxt.height = cfg_wdata;
          restart        = 1'b1;
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt    <= 3'(FMT_BGRA32);
      cfg_r.width  <= 9'd256;
      cfg_r.height <= 9'd256;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = status.in_ready;
  assign acc       = in_tvalid && in_tready;
  assign acc_pixel = acc && (in_tuser == CMD_PIXEL);
  assign pal_we    = acc && (in_tuser == CMD_PALETTE)
                     && ({1'b0, in_tdata[7:0]} < 9'(PALETTE_DEPTH));

  bpu_byte_sequencer #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .restart   (restart),
    .adv       (adv),
    .acc_pixel (acc_pixel),
    .data_byte (in_tdata[47:40]),
    .issue     (issue),
    .status    (status)
  );

  bpu_palette_ram #(
    .DEPTH(PALETTE_DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_tdata[AW-1:0]),
    .wdata (in_tdata[39:8]),
    .re    (adv),
    .raddr (issue.pal_idx[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      m_valid_r   <= issue.valid;
      out_valid_r <= m_valid_r;
    end
  end

  always_comb begin
    if (m_direct_r) begin
      color_nxt = m_color_r;
    end else if (m_oob_r) begin
      color_nxt = 32'd0;
    end else begin
      color_nxt = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_direct_r <= issue.direct;
      m_oob_r    <= {1'b0, issue.pal_idx} >= 9'(PALETTE_DEPTH);
      m_color_r  <= issue.color;
      m_col_r    <= issue.col;
      m_row_r    <= issue.row;
      m_last_r   <= issue.last;
      m_done_r   <= issue.done;
      out_data_r <= {m_row_r, m_col_r, color_nxt[31:24], color_nxt[7:0],
                     color_nxt[15:8], color_nxt[23:16]};
      out_last_r <= m_last_r;
      out_done_r <= m_done_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("final pixel of the image is not the last pixel of its byte");

  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.left <= 4'd8)
    else $error("sequencer holds more than eight pixels");

  a_palette_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_tuser == CMD_PALETTE) |=> status.left == 4'd0)
    else $error("sequencer busy after a palette write transaction");
`endif

endmodule

/* verif/bitmap_pixel_unpacker_tb.sv */
// ----------------------------------------------------------------------------
// bitmap_pixel_unpacker_tb
// Self-checking testbench for the bitmap pixel unpacker. It loads the low
// palette entries and then walks a short directed script over every pixel
// format, padding and image end. Random phases follow across many register
// settings, including out-of-range formats and sizes. A local decoder predicts
// every pixel, and each received pixel is compared field by field with the
// oldest prediction. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module bitmap_pixel_unpacker_tb;
  import bpu_pkg::*;

  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int PAL_DEPTH = DEF_PALETTE_DEPTH;
  localparam int PAL_PRELOAD = 32;
  localparam int DRAIN_CYCLES = 24;
  localparam int STALL_CYCLES = 80;
  localparam int N_PHASES = 11;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] column;
    logic [7:0] row;
    logic       last;
    logic       done;
  } pixel_t;

  typedef enum {CHECK_PREDICTED, CHECK_NO_PIXEL, CHECK_TYPED} check_t;

  typedef struct {
    bit          is_cfg;
    cfg_idx_t    reg_idx;
    logic [8:0]  reg_val;
    logic        cmd;
    logic [7:0]  pal_idx;
    logic [31:0] color;
    logic [7:0]  data;
    check_t      check;
    pixel_t      typed;
  } step_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  logic [8:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  pixel_t pending_pixels[$];
  pixel_t fresh_pixels[$];
  step_t  script[$];
  pixel_t oldest;
  int     errors;
  int     send_gap_pct;
  int     recv_gap_pct;
  bit     stall_request;

  logic [2:0]  fmt_shadow;
  logic [8:0]  width_shadow;
  logic [8:0]  height_shadow;
  logic [31:0] palette_shadow [PAL_DEPTH];
  int          byte_pos;
  int          pix_col;
  int          file_row;
  int          lane;
  logic [23:0] gathered;

  int unsigned phase_fmt [N_PHASES] = '{FMT_1BIT, FMT_4BIT, FMT_8BIT, FMT_BGR24, 7,
                                        FMT_BGRA32, FMT_1BIT, 5, 6, FMT_4BIT, FMT_8BIT};
  int unsigned phase_w   [N_PHASES] = '{13, 5, 256, 2, 0, 1, 511, 300, 2, 256, 3};
  int unsigned phase_h   [N_PHASES] = '{3, 2, 1, 3, 0, 2, 256, 1, 1, 256, 2};
  int unsigned phase_len [N_PHASES] = '{16, 12, 12, 12, 8, 10, 24, 12, 8, 12, 12};

  bitmap_pixel_unpacker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("bitmap_pixel_unpacker_tb failed");
    $finish;
  end

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_field(string what, logic [47:0] got, logic [47:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  function automatic void restart_image();
    byte_pos = 0;
    pix_col = 0;
    file_row = 0;
    gathered = '0;
    lane = 0;
  endfunction

  function automatic logic [31:0] palette_lookup(logic [7:0] i);
    return (i < PAL_DEPTH) ? palette_shadow[i] : 32'h0;
  endfunction

  function automatic void emit_pixel(logic [31:0] bgra, int w, int h);
    pixel_t p;
    int r;
    r = h - 1 - file_row;
    p.red = bgra[23:16];
    p.green = bgra[15:8];
    p.blue = bgra[7:0];
    p.alpha = bgra[31:24];
    p.column = pix_col[7:0];
    p.row = r[7:0];
    p.last = 1'b0;
    p.done = (file_row == h - 1) && (pix_col == w - 1);
    fresh_pixels.push_back(p);
    pix_col++;
  endfunction

  function automatic void decode_transaction(logic cmd, logic [7:0] pi, logic [31:0] color,
                                             logic [7:0] data);
    fmt_t f;
    int w, h, n_bytes, stride, lanes, s;
    logic [31:0] px;
    pixel_t tail;
    fresh_pixels.delete();
    if (cmd == CMD_PALETTE) begin
      if (pi < PAL_DEPTH) palette_shadow[pi] = color;
      return;
    end
    f = (fmt_shadow > 3'(FMT_BGRA32)) ? FMT_BGRA32 : fmt_t'(fmt_shadow);
    w = (width_shadow == 0) ? 1 : ((width_shadow > MAX_W) ? MAX_W : width_shadow);
    h = (height_shadow == 0) ? 1 : ((height_shadow > 256) ? 256 : height_shadow);
    case (f)
      FMT_1BIT:  n_bytes = (w + 7) / 8;
      FMT_4BIT:  n_bytes = (w + 1) / 2;
      FMT_8BIT:  n_bytes = w;
      FMT_BGR24: n_bytes = w * 3;
      default:   n_bytes = w * 4;
    endcase
    stride = (n_bytes + 3) / 4 * 4;
    if (file_row >= h) file_row = 0;
    if (byte_pos < n_bytes) begin
      case (f)
        FMT_1BIT: begin
          for (s = 7; s >= 0; s--)
            if (pix_col < w) emit_pixel(palette_lookup({7'd0, data[s]}), w, h);
        end
        FMT_4BIT: begin
          if (pix_col < w) emit_pixel(palette_lookup({4'd0, data[7:4]}), w, h);
          if (pix_col < w) emit_pixel(palette_lookup({4'd0, data[3:0]}), w, h);
        end
        FMT_8BIT: begin
          if (pix_col < w) emit_pixel(palette_lookup(data), w, h);
        end
        default: begin
          lanes = (f == FMT_BGR24) ? 3 : 4;
          if (lane + 1 < lanes) begin
            gathered[8*lane +: 8] = data;
            lane++;
          end else begin
            px = (f == FMT_BGR24) ? {8'hFF, data, gathered[15:0]} : {data, gathered};
            if (pix_col < w) emit_pixel(px, w, h);
            gathered = '0;
            lane = 0;
          end
        end
      endcase
    end
    if (fresh_pixels.size() > 0) begin
      tail = fresh_pixels.pop_back();
      tail.last = 1'b1;
      fresh_pixels.push_back(tail);
    end
    if (byte_pos + 1 >= stride) begin
      byte_pos = 0;
      pix_col = 0;
      gathered = '0;
      lane = 0;
      file_row++;
      if (file_row >= h) file_row = 0;
    end else begin
      byte_pos++;
    end
  endfunction

  function automatic void add_cfg(cfg_idx_t r, logic [8:0] v);
    step_t s;
    s.is_cfg = 1'b1;
    s.reg_idx = r;
    s.reg_val = v;
    script.push_back(s);
  endfunction

  function automatic void add_item(logic cmd, logic [7:0] pi, logic [31:0] color,
                                   logic [7:0] data, check_t check, pixel_t typed);
    step_t s;
    s.is_cfg = 1'b0;
    s.cmd = cmd;
    s.pal_idx = pi;
    s.color = color;
    s.data = data;
    s.check = check;
    s.typed = typed;
    script.push_back(s);
  endfunction

  task automatic send_item(logic cmd, logic [7:0] pi, logic [31:0] color, logic [7:0] data,
                           check_t check, pixel_t typed);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = {data, color, pi};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_transaction(cmd, pi, color, data);
    if (check == CHECK_PREDICTED) begin
      foreach (fresh_pixels[i]) pending_pixels.push_back(fresh_pixels[i]);
    end else if (check == CHECK_TYPED) begin
      pending_pixels.push_back(typed);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t r, logic [8:0] v);
    in_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = r;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    case (r)
      CFG_FORMAT: fmt_shadow = v[2:0];
      CFG_WIDTH:  width_shadow = v;
      CFG_HEIGHT: height_shadow = v;
      default:    ;
    endcase
    restart_image();
  endtask

  initial begin
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        hold = STALL_CYCLES;
        stall_request = 1'b0;
      end
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else begin
        out_tready = ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel", out_tdata, 48'h0);
      end else begin
        oldest = pending_pixels.pop_front();
        check_field("red", out_tdata[7:0], oldest.red);
        check_field("green", out_tdata[15:8], oldest.green);
        check_field("blue", out_tdata[23:16], oldest.blue);
        check_field("alpha", out_tdata[31:24], oldest.alpha);
        check_field("column", out_tdata[39:32], oldest.column);
        check_field("row", out_tdata[47:40], oldest.row);
        check_field("last_of_run", out_tlast, oldest.last);
        check_field("image_done", out_tuser, oldest.done);
      end
    end
  end

  initial begin
    int k, p;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FORMAT;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_PALETTE;
    errors = 0;
    send_gap_pct = 37;
    recv_gap_pct = 83;
    stall_request = 1'b0;
    fmt_shadow = FMT_BGRA32;
    width_shadow = 9'd256;
    height_shadow = 9'd256;
    restart_image();

    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'h00, CHECK_NO_PIXEL, '0);
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'hFF, CHECK_NO_PIXEL, '0);
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'h5A, CHECK_NO_PIXEL, '0);
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'hA5, CHECK_TYPED,
             pixel_t'{8'h5A, 8'hFF, 8'h00, 8'hA5, 8'd0, 8'd255, 1'b1, 1'b0});
    add_item(CMD_PALETTE, 8'd0, 32'h0000_0000, 8'h00, CHECK_NO_PIXEL, '0);
    add_item(CMD_PALETTE, 8'd255, 32'hFFFF_FFFF, 8'hFF, CHECK_NO_PIXEL, '0);
    add_item(CMD_PALETTE, 8'd1, 32'h8040_2010, 8'h00, CHECK_NO_PIXEL, '0);
    add_cfg(CFG_FORMAT, {6'd0, FMT_1BIT});
    add_cfg(CFG_WIDTH, 9'd9);
    add_cfg(CFG_HEIGHT, 9'd1);
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'hA5, CHECK_PREDICTED, '0);
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'h80, CHECK_PREDICTED, '0);
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'h00, CHECK_NO_PIXEL, '0);
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'hFF, CHECK_NO_PIXEL, '0);
    add_cfg(CFG_FORMAT, {6'd0, FMT_4BIT});
    add_cfg(CFG_WIDTH, 9'd3);
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'h0F, CHECK_PREDICTED, '0);
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'hF1, CHECK_PREDICTED, '0);
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'hFF, CHECK_NO_PIXEL, '0);
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'h00, CHECK_NO_PIXEL, '0);
    add_cfg(CFG_FORMAT, {6'd0, FMT_8BIT});
    add_cfg(CFG_WIDTH, 9'd1);
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'hFF, CHECK_TYPED,
             pixel_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd0, 8'd0, 1'b1, 1'b1});
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'h00, CHECK_NO_PIXEL, '0);
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'hFF, CHECK_NO_PIXEL, '0);
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'h00, CHECK_NO_PIXEL, '0);
    add_cfg(CFG_FORMAT, {6'd0, FMT_BGR24});
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'h01, CHECK_NO_PIXEL, '0);
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'h02, CHECK_NO_PIXEL, '0);
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'h03, CHECK_TYPED,
             pixel_t'{8'h03, 8'h02, 8'h01, 8'hFF, 8'd0, 8'd0, 1'b1, 1'b1});
    add_item(CMD_PIXEL, 8'h00, 32'h0, 8'hFF, CHECK_NO_PIXEL, '0);

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    for (k = 0; k < PAL_PRELOAD; k++)
      send_item(CMD_PALETTE, k[7:0], $urandom, 8'($urandom_range(0, 255)),
                CHECK_PREDICTED, '0);

    foreach (script[i]) begin
      if (script[i].is_cfg)
        write_reg(script[i].reg_idx, script[i].reg_val);
      else
        send_item(script[i].cmd, script[i].pal_idx, script[i].color, script[i].data,
                  script[i].check, script[i].typed);
    end

    for (p = 0; p < N_PHASES; p++) begin
      if (p == 3) begin
        send_gap_pct = 83;
        recv_gap_pct = 37;
      end
      if (p == 6) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      write_reg(CFG_FORMAT, 9'(phase_fmt[p]));
      write_reg(CFG_WIDTH, 9'(phase_w[p]));
      write_reg(CFG_HEIGHT, 9'(phase_h[p]));
      if (p == 6) stall_request = 1'b1;
      for (k = 0; k < int'(phase_len[p]); k++) begin
        if (p == N_PHASES - 1 && k == int'(phase_len[p]) / 2) begin
          in_tvalid = 1'b0;
          while (pending_pixels.size() != 0) @(negedge clk);
        end
        if ($urandom_range(0, 99) < 15)
          send_item(CMD_PALETTE, 8'($urandom_range(0, 255)), $urandom,
                    8'($urandom_range(0, 255)), CHECK_PREDICTED, '0);
        else
          send_item(CMD_PIXEL, 8'($urandom_range(0, 255)), $urandom,
                    (phase_fmt[p] == FMT_8BIT) ? 8'($urandom_range(0, PAL_PRELOAD - 1))
                                               : 8'($urandom_range(0, 255)),
                    CHECK_PREDICTED, '0);
      end
    end

    in_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("bitmap_pixel_unpacker_tb passed");
    end else begin
      $display("bitmap_pixel_unpacker_tb failed");
    end
    $finish;
  end

endmodule
